### src/fsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants for the frame slot presenter.
// ----------------------------------------------------------------------------
package fsp_pkg;
  localparam int SLOTS = 8;
  localparam int SW = $clog2(SLOTS);

  typedef enum logic [2:0] {
    ST_EMPTY = 3'd0, ST_FILLING = 3'd1, ST_READY = 3'd2,
    ST_DISPLAYING = 3'd3, ST_RETIRING = 3'd4
  } slot_st_t;

  typedef enum logic [2:0] {
    OP_CLAIM = 3'd0, OP_FILL = 3'd1, OP_PRESENT = 3'd2,
    OP_SEEK = 3'd3, OP_LAND = 3'd4, OP_PAUSE = 3'd5
  } op_t;

  localparam logic CFG_PREROLL = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam logic [62:0] M63 = {63{1'b1}};

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;      // capture input item
    logic scan;      // step the slot scan
    logic clk_calc;  // compute presentation clock
    logic do_op;     // apply the operation
    logic emit;      // drive the result
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;
endpackage
`default_nettype wire

### src/frame_slot_presenter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_slot_presenter
// Frame slot ring with pre-roll gated presentation clock.
// ----------------------------------------------------------------------------
// Usage: raise start with an operation on the in_ ports while busy is low; the
// item is taken at that edge and busy stays high until the result is strobed.
// Each item yields one result on the out_ ports, valid for one cycle with
// out_valid. The item is captured at the accepting edge, then come eight scan
// steps (one slot each), one clock step, one apply and one emit, and out_valid
// is registered from the emit step. Busy falls while the result is strobed,
// so the next item can be taken at the same edge. The slot scan is the
// longest step of the sequence.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high and a beat should only be sent while the block is idle.
// Reset (synchronous, rst_n low) empties every slot, stops the clock and
// restores pre-roll to four frames and the audio timeout to five seconds.
// The receiver cannot stall: results must be taken when strobed.
// ----------------------------------------------------------------------------
module frame_slot_presenter import fsp_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire  [2:0]  in_opcode,
  input  wire  [2:0]  in_slot_sel,
  input  wire  [62:0] in_time_ns,
  input  wire  [12:0] in_frame_w,
  input  wire  [12:0] in_frame_h,
  input  wire         in_decode_ok,
  input  wire  [47:0] in_now_us,
  input  wire         in_audio_hold,
  input  wire         in_use_audio_clock,
  input  wire  [62:0] in_audio_clock_ns,
  input  wire         in_pause_on,
  output logic        out_valid,
  output logic        out_claim_ok,
  output logic [2:0]  out_slot_out,
  output logic        out_frame_shown,
  output logic [12:0] out_show_w,
  output logic [12:0] out_show_h,
  output logic        out_release_audio,
  output logic        out_stream_done,
  output logic [62:0] out_position_ns
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fsp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  fsp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_opcode(in_opcode), .in_slot_sel(in_slot_sel), .in_time_ns(in_time_ns),
    .in_frame_w(in_frame_w), .in_frame_h(in_frame_h), .in_decode_ok(in_decode_ok),
    .in_now_us(in_now_us), .in_audio_hold(in_audio_hold),
    .in_use_audio_clock(in_use_audio_clock), .in_audio_clock_ns(in_audio_clock_ns),
    .in_pause_on(in_pause_on),
    .out_valid(out_valid), .out_claim_ok(out_claim_ok), .out_slot_out(out_slot_out),
    .out_frame_shown(out_frame_shown), .out_show_w(out_show_w), .out_show_h(out_show_h),
    .out_release_audio(out_release_audio), .out_stream_done(out_stream_done),
    .out_position_ns(out_position_ns)
  );
endmodule
`default_nettype wire

### src/fsp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_ctrl
// Sequencer: capture, slot scan, clock compute, apply, emit.
// ----------------------------------------------------------------------------
module fsp_ctrl import fsp_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  start,
  output logic busy,
  output cmd_t cmd,
  input  sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_CLK = 5'b00100,
    S_APPLY = 5'b01000, S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_CLK;
      end
      S_CLK: begin
        cmd.clk_calc = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.do_op = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

### src/fsp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsp_dp
// Slot store, scan unit, presentation clock and result register.
// ----------------------------------------------------------------------------
module fsp_dp import fsp_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  wire         cfg_valid,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire  [2:0]  in_opcode,
  input  wire  [2:0]  in_slot_sel,
  input  wire  [62:0] in_time_ns,
  input  wire  [12:0] in_frame_w,
  input  wire  [12:0] in_frame_h,
  input  wire         in_decode_ok,
  input  wire  [47:0] in_now_us,
  input  wire         in_audio_hold,
  input  wire         in_use_audio_clock,
  input  wire  [62:0] in_audio_clock_ns,
  input  wire         in_pause_on,
  output logic        out_valid,
  output logic        out_claim_ok,
  output logic [2:0]  out_slot_out,
  output logic        out_frame_shown,
  output logic [12:0] out_show_w,
  output logic [12:0] out_show_h,
  output logic        out_release_audio,
  output logic        out_stream_done,
  output logic [62:0] out_position_ns
);
  slot_st_t    st_r [SLOTS];
  logic [62:0] pts_r [SLOTS];
  logic [12:0] w_r [SLOTS];
  logic [12:0] h_r [SLOTS];

  logic [3:0]  preroll_r;
  logic [31:0] tmo_r;
  logic started_r, ended_r, seek_r, paused_r, amode_r, shown_v_r;
  logic [SW-1:0] shown_r;
  logic [62:0] base_pts_r, pos_r;
  logic [47:0] base_wall_r, pause_wall_r, wait_r;

  // captured item
  logic [2:0]  op_r;
  logic [SW-1:0] sel_r;
  logic [62:0] t_r, ans_r;
  logic [12:0] fw_r, fh_r;
  logic ok_r, hold_r, use_r, pon_r;
  logic [47:0] now_r;

  // scan
  logic [SW:0]   idx_r;
  logic [SW-1:0] idx;
  logic          empty_f_r, early_f_r;
  logic [SW-1:0] empty_i_r;
  logic [62:0]   early_r;
  logic [SW:0]   ready_cnt_r;

  // present clock and selection
  logic [62:0] clk_r;
  logic        go_r;            // present proceeds to selection this item
  logic        rel_r;
  logic [63:0] wall_prod;
  logic [47:0] wait_d;
  logic        busy_any;        // some slot ready or filling

  assign idx = idx_r[SW-1:0];
  assign sts.scan_last = (idx_r == (SW+1)'(SLOTS - 1));

  // The best due ready frame needs the presentation clock, so selection runs
  // in the apply step as a parallel compare over the eight slots.
  logic          sel_ok;
  logic [SW-1:0] sel_i;
  logic [62:0]   sel_pts;
  always_comb begin
    sel_ok = 1'b0;
    sel_i = '0;
    sel_pts = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (st_r[i] == ST_READY && pts_r[i] <= clk_r && (!sel_ok || pts_r[i] >= sel_pts)) begin
        sel_ok = 1'b1;
        sel_i = SW'(i);
        sel_pts = pts_r[i];
      end
    end
  end

  always_comb begin
    busy_any = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (st_r[i] == ST_READY || st_r[i] == ST_FILLING) busy_any = 1'b1;
  end

  assign wait_d = now_r - wait_r;

  // Clock-step combinational evaluation.
  logic warm, waiting, c_go, c_rel, c_started, c_amode;
  logic [62:0] c_bpts;
  logic [47:0] c_bwall, c_wait, wd;
  logic [63:0] c_sum;
  always_comb begin
    c_started = started_r;
    c_rel = 1'b0;
    c_go = 1'b0;
    c_bpts = base_pts_r;
    c_bwall = base_wall_r;
    c_wait = wait_r;
    c_amode = amode_r;
    warm = (ready_cnt_r >= preroll_r) || ended_r;
    waiting = hold_r;
    if (!seek_r) begin
      c_go = 1'b1;
      if (!started_r) begin
        if (waiting) begin
          if (wait_r == 48'd0) c_wait = now_r;
          else if ({16'd0, wait_d} > {32'd0, tmo_r}) waiting = 1'b0;
        end
        if (!early_f_r || !warm || waiting) c_go = 1'b0;
        else begin
          c_bpts = early_r;
          c_bwall = now_r;
          c_started = 1'b1;
          c_rel = 1'b1;
        end
      end
      if (c_go && c_amode && (!use_r || ended_r)) begin
        c_amode = 1'b0;
        c_bpts = pos_r;
        c_bwall = now_r;
      end
      if (c_go && use_r && !ended_r) c_amode = 1'b1;
    end
    // wall clock: 48-bit delta times 1000 split as (d<<10) - (d<<4) - (d<<3)
    wd = now_r - c_bwall;
    wall_prod = ({16'd0, wd} << 10) - ({16'd0, wd} << 4) - ({16'd0, wd} << 3);
    c_sum = {1'b0, c_bpts} + wall_prod;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      sel_r <= SW'(in_slot_sel);
      t_r <= in_time_ns;
      fw_r <= in_frame_w;
      fh_r <= in_frame_h;
      ok_r <= in_decode_ok;
      now_r <= in_now_us;
      hold_r <= in_audio_hold;
      use_r <= in_use_audio_clock;
      ans_r <= in_audio_clock_ns;
      pon_r <= in_pause_on;
    end
    if (cmd.clk_calc) begin
      if (use_r && !ended_r) clk_r <= ans_r;
      else if (paused_r) clk_r <= pos_r;
      else clk_r <= c_sum[63] ? M63 : c_sum[62:0];
    end
    if (cmd.do_op && op_r == OP_FILL && st_r[sel_r] == ST_FILLING && ok_r) begin
      pts_r[sel_r] <= t_r;
      w_r[sel_r] <= fw_r;
      h_r[sel_r] <= fh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) st_r[i] <= ST_EMPTY;
      preroll_r <= 4'd4;
      tmo_r <= 32'd5000000;
      started_r <= 1'b0; ended_r <= 1'b0; seek_r <= 1'b0;
      paused_r <= 1'b0; amode_r <= 1'b0; shown_v_r <= 1'b0;
      shown_r <= '0;
      base_pts_r <= '0; pos_r <= '0;
      base_wall_r <= '0; pause_wall_r <= '0; wait_r <= '0;
      idx_r <= '0;
      empty_f_r <= 1'b0; early_f_r <= 1'b0; empty_i_r <= '0;
      early_r <= '0; ready_cnt_r <= '0;
      go_r <= 1'b0; rel_r <= 1'b0;
      out_valid <= 1'b0;
      out_claim_ok <= 1'b0; out_slot_out <= '0; out_frame_shown <= 1'b0;
      out_show_w <= '0; out_show_h <= '0; out_release_audio <= 1'b0;
      out_stream_done <= 1'b0; out_position_ns <= '0;
    end else begin
      out_valid <= cmd.emit;
      if (cfg_valid) begin
        if (cfg_index == CFG_PREROLL) preroll_r <= cfg_data[3:0];
        else tmo_r <= cfg_data;
      end
      if (cmd.load) begin
        idx_r <= '0;
        empty_f_r <= 1'b0; early_f_r <= 1'b0;
        ready_cnt_r <= '0;
      end
      if (cmd.scan) begin
        idx_r <= idx_r + 1'b1;
        if (st_r[idx] == ST_EMPTY && !empty_f_r) begin
          empty_f_r <= 1'b1;
          empty_i_r <= idx;
        end
        if (st_r[idx] == ST_READY) begin
          ready_cnt_r <= ready_cnt_r + 1'b1;
          if (!early_f_r || pts_r[idx] < early_r) begin
            early_r <= pts_r[idx];
            early_f_r <= 1'b1;
          end
        end
      end
      if (cmd.clk_calc && op_r == OP_PRESENT) begin
        go_r <= c_go;
        rel_r <= c_rel;
        started_r <= c_started;
        base_pts_r <= c_bpts;
        base_wall_r <= c_bwall;
        wait_r <= c_wait;
        amode_r <= c_amode;
      end else if (cmd.clk_calc) begin
        go_r <= 1'b0;
        rel_r <= 1'b0;
      end
      if (cmd.do_op) begin
        unique case (op_r)
          OP_CLAIM: begin
            if (empty_f_r) st_r[empty_i_r] <= ST_FILLING;
          end
          OP_FILL: begin
            if (st_r[sel_r] == ST_FILLING) begin
              if (ok_r) st_r[sel_r] <= ST_READY;
              else begin
                st_r[sel_r] <= ST_EMPTY;
                if (!seek_r) ended_r <= 1'b1;
              end
            end
          end
          OP_PRESENT: begin
            if (go_r && sel_ok) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (SW'(i) == sel_i) st_r[i] <= ST_DISPLAYING;
                else if (st_r[i] == ST_RETIRING) st_r[i] <= ST_EMPTY;
                else if (st_r[i] == ST_DISPLAYING) st_r[i] <= ST_RETIRING;
                else if (st_r[i] == ST_READY && pts_r[i] < sel_pts) st_r[i] <= ST_EMPTY;
              end
              shown_v_r <= 1'b1;
              shown_r <= sel_i;
              pos_r <= sel_pts;
            end
          end
          OP_SEEK: begin
            pos_r <= t_r;
            seek_r <= 1'b1;
          end
          OP_LAND: begin
            if (seek_r) begin
              for (int i = 0; i < SLOTS; i++)
                if (st_r[i] == ST_READY) st_r[i] <= ST_EMPTY;
              started_r <= 1'b0; ended_r <= 1'b0;
              pos_r <= t_r; base_pts_r <= t_r;
              amode_r <= 1'b0; wait_r <= '0; seek_r <= 1'b0;
            end
          end
          OP_PAUSE: begin
            if (pon_r && !paused_r) begin
              paused_r <= 1'b1;
              pause_wall_r <= now_r;
            end else if (!pon_r && paused_r) begin
              paused_r <= 1'b0;
              base_wall_r <= base_wall_r + (now_r - pause_wall_r);
            end
          end
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_claim_ok <= (op_r == OP_CLAIM) && empty_f_r;
        // For a present, the shown frame is returned when a seek is pending or the clock runs.
        if (op_r == OP_PRESENT && shown_v_r && (seek_r || go_r)) begin
          out_slot_out <= 3'(shown_r);
          out_frame_shown <= 1'b1;
          out_show_w <= w_r[shown_r];
          out_show_h <= h_r[shown_r];
        end else begin
          out_slot_out <= (op_r == OP_CLAIM && empty_f_r) ? 3'(empty_i_r) : 3'd0;
          out_frame_shown <= 1'b0;
          out_show_w <= '0;
          out_show_h <= '0;
        end
        out_release_audio <= rel_r;
        out_stream_done <= ended_r && !busy_any;
        out_position_ns <= pos_r;
      end
    end
  end
endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame slot presenter: a directed table, then
// random playback sessions under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import fsp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int N_RANDOM = 1100;
  localparam logic [47:0] M48 = {48{1'b1}};

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  slot_sel;
    logic [62:0] time_ns;
    logic [12:0] frame_w;
    logic [12:0] frame_h;
    logic        decode_ok;
    logic [47:0] now_us;
    logic        audio_hold;
    logic        use_audio;
    logic [62:0] audio_ns;
    logic        pause_on;
  } op_item_t;

  typedef struct packed {
    logic        claim_ok;
    logic [2:0]  slot_out;
    logic        frame_shown;
    logic [12:0] show_w;
    logic [12:0] show_h;
    logic        release_audio;
    logic        stream_done;
    logic [62:0] position_ns;
  } view_t;

  typedef struct packed {
    op_item_t item;
    logic     typed;
    view_t    view;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic [2:0] in_opcode = '0;
  logic [2:0] in_slot_sel = '0;
  logic [62:0] in_time_ns = '0;
  logic [12:0] in_frame_w = '0;
  logic [12:0] in_frame_h = '0;
  logic in_decode_ok = 1'b0;
  logic [47:0] in_now_us = '0;
  logic in_audio_hold = 1'b0;
  logic in_use_audio_clock = 1'b0;
  logic [62:0] in_audio_clock_ns = '0;
  logic in_pause_on = 1'b0;
  logic out_valid;
  logic out_claim_ok;
  logic [2:0] out_slot_out;
  logic out_frame_shown;
  logic [12:0] out_show_w;
  logic [12:0] out_show_h;
  logic out_release_audio;
  logic out_stream_done;
  logic [62:0] out_position_ns;

  always #1 clk = ~clk;

  frame_slot_presenter dut (.*);

  // Predictor state.
  slot_st_t    slot_state [SLOTS];
  logic [62:0] slot_pts [SLOTS];
  logic [12:0] slot_wd [SLOTS];
  logic [12:0] slot_ht [SLOTS];
  logic clock_run, ended, seek_wait, paused, on_audio, have_shown;
  logic [62:0] anchor_pts, position;
  logic [47:0] anchor_wall, paused_at, audio_wait_t0;
  logic [2:0] shown_idx;
  logic [3:0] preroll_need;
  logic [31:0] audio_wait_limit;

  view_t expected_views[$];
  int errors = 0;
  int cycles = 0;

  // Session generator state.
  logic [62:0] next_pts, seek_target;
  logic [47:0] wall_us;
  int idle_pct;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic done_now();
    logic d;
    d = ended;
    for (int i = 0; i < SLOTS; i++)
      if (slot_state[i] == ST_READY || slot_state[i] == ST_FILLING) d = 1'b0;
    return d;
  endfunction

  function automatic void show_current(inout view_t v);
    if (have_shown) begin
      v.slot_out = shown_idx;
      v.frame_shown = 1'b1;
      v.show_w = slot_wd[shown_idx];
      v.show_h = slot_ht[shown_idx];
    end
  endfunction

  function automatic void predict_present(input op_item_t it, inout view_t v);
    int ready;
    logic found, best_ok, warm, waiting;
    int best;
    logic [62:0] earliest, best_pts;
    logic [63:0] pace;
    ready = 0; found = 0; best_ok = 0; best = 0; earliest = '0; best_pts = '0;
    if (seek_wait) begin
      show_current(v);
      return;
    end
    if (!clock_run) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_state[i] == ST_READY) begin
          ready++;
          if (!found || slot_pts[i] < earliest) begin
            earliest = slot_pts[i];
            found = 1'b1;
          end
        end
      warm = (ready >= preroll_need) || ended;
      waiting = it.audio_hold;
      if (waiting) begin
        if (audio_wait_t0 == '0) audio_wait_t0 = it.now_us;
        else if (48'(it.now_us - audio_wait_t0) > {16'd0, audio_wait_limit}) waiting = 1'b0;
      end
      if (!found || !warm || waiting) return;
      anchor_pts = earliest;
      anchor_wall = it.now_us;
      clock_run = 1'b1;
      v.release_audio = 1'b1;
    end
    // Losing the audio clock re-anchors the wall clock at the current position.
    if (on_audio && (!it.use_audio || ended)) begin
      on_audio = 1'b0;
      anchor_pts = position;
      anchor_wall = it.now_us;
    end
    if (it.use_audio && !ended) begin
      on_audio = 1'b1;
      pace = {1'b0, it.audio_ns};
    end else if (paused) begin
      pace = {1'b0, position};
    end else begin
      pace = {1'b0, anchor_pts} + 64'(48'(it.now_us - anchor_wall)) * 64'd1000;
      if (pace > {1'b0, M63}) pace = {1'b0, M63};
    end
    for (int i = 0; i < SLOTS; i++)
      if (slot_state[i] == ST_READY && {1'b0, slot_pts[i]} <= pace &&
          (!best_ok || slot_pts[i] >= best_pts)) begin
        best = i;
        best_pts = slot_pts[i];
        best_ok = 1'b1;
      end
    if (best_ok) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_state[i] == ST_RETIRING) slot_state[i] = ST_EMPTY;
        else if (slot_state[i] == ST_DISPLAYING) slot_state[i] = ST_RETIRING;
        else if (slot_state[i] == ST_READY && slot_pts[i] < best_pts) slot_state[i] = ST_EMPTY;
      slot_state[best] = ST_DISPLAYING;
      have_shown = 1'b1;
      shown_idx = 3'(best);
      position = best_pts;
    end
    show_current(v);
  endfunction

  function automatic view_t predict_view(input op_item_t it);
    view_t v;
    logic hit;
    v = '0;
    hit = 1'b0;
    case (it.opcode)
      OP_CLAIM: begin
        for (int i = 0; i < SLOTS; i++)
          if (!hit && slot_state[i] == ST_EMPTY) begin
            slot_state[i] = ST_FILLING;
            v.claim_ok = 1'b1;
            v.slot_out = 3'(i);
            hit = 1'b1;
          end
      end
      OP_FILL: begin
        if (slot_state[it.slot_sel] == ST_FILLING) begin
          if (it.decode_ok) begin
            slot_pts[it.slot_sel] = it.time_ns;
            slot_wd[it.slot_sel] = it.frame_w;
            slot_ht[it.slot_sel] = it.frame_h;
            slot_state[it.slot_sel] = ST_READY;
          end else begin
            slot_state[it.slot_sel] = ST_EMPTY;
            if (!seek_wait) ended = 1'b1;
          end
        end
      end
      OP_PRESENT: predict_present(it, v);
      OP_SEEK: begin
        position = it.time_ns;
        seek_wait = 1'b1;
      end
      OP_LAND: begin
        if (seek_wait) begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_state[i] == ST_READY) slot_state[i] = ST_EMPTY;
          clock_run = 1'b0;
          ended = 1'b0;
          position = it.time_ns;
          anchor_pts = it.time_ns;
          on_audio = 1'b0;
          audio_wait_t0 = '0;
          seek_wait = 1'b0;
        end
      end
      OP_PAUSE: begin
        if (it.pause_on && !paused) begin
          paused = 1'b1;
          paused_at = it.now_us;
        end else if (!it.pause_on && paused) begin
          paused = 1'b0;
          anchor_wall = anchor_wall + 48'(it.now_us - paused_at);
        end
      end
      default: ;
    endcase
    v.stream_done = done_now();
    v.position_ns = position;
    return v;
  endfunction

  // Drives one beat and waits for it to be taken; start is left high.
  task automatic issue(input op_item_t it, input logic typed, input view_t typed_view);
    view_t v;
    in_opcode <= it.opcode;
    in_slot_sel <= it.slot_sel;
    in_time_ns <= it.time_ns;
    in_frame_w <= it.frame_w;
    in_frame_h <= it.frame_h;
    in_decode_ok <= it.decode_ok;
    in_now_us <= it.now_us;
    in_audio_hold <= it.audio_hold;
    in_use_audio_clock <= it.use_audio;
    in_audio_clock_ns <= it.audio_ns;
    in_pause_on <= it.pause_on;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    v = predict_view(it);
    expected_views.push_back(typed ? typed_view : v);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PREROLL) preroll_need = data[3:0];
    else audio_wait_limit = data;
  endtask

  function automatic op_item_t noise_item();
    op_item_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(op_item_t)-1:0];
    return it;
  endfunction

  // A playback session step: mostly well-formed, with some noise mixed in.
  function automatic op_item_t session_item();
    op_item_t it;
    int r, s0;
    it = noise_item();
    r = $urandom_range(99);
    wall_us = wall_us + 48'($urandom_range(40000, 1000));
    it.now_us = wall_us;
    it.audio_hold = ($urandom_range(99) < 12);
    it.use_audio = ($urandom_range(99) < 20);
    it.audio_ns = next_pts - 63'($urandom_range(90000000));
    if (r < 8) return noise_item();
    if (r < 28) it.opcode = OP_CLAIM;
    else if (r < 55) begin
      it.opcode = OP_FILL;
      s0 = $urandom_range(SLOTS - 1);
      for (int k = 0; k < SLOTS; k++)
        if (slot_state[(s0 + k) % SLOTS] == ST_FILLING) it.slot_sel = 3'((s0 + k) % SLOTS);
      it.decode_ok = ($urandom_range(99) < 95);
      it.time_ns = next_pts;
      next_pts = next_pts + 63'($urandom_range(40000000, 20000000));
    end else if (r < 85) it.opcode = OP_PRESENT;
    else if (r < 90) begin
      it.opcode = OP_SEEK;
      seek_target = 63'($urandom_range(32'h7fffffff)) * 63'd8;
      it.time_ns = seek_target;
    end else if (r < 95) begin
      it.opcode = OP_LAND;
      it.time_ns = seek_target;
      next_pts = seek_target;
    end else it.opcode = OP_PAUSE;
    return it;
  endfunction

  function automatic dir_row_t row(input logic [2:0] op, input logic [2:0] sel,
                                   input logic [62:0] t, input logic [12:0] w,
                                   input logic [12:0] h, input logic ok,
                                   input logic [47:0] now, input logic hold,
                                   input logic pz);
    dir_row_t d;
    d = '0;
    d.item = '{op, sel, t, w, h, ok, now, hold, 1'b0, 63'd0, pz};
    return d;
  endfunction

  function automatic dir_row_t typed_row(input dir_row_t d, input logic cok,
                                         input logic [2:0] slot);
    d.typed = 1'b1;
    d.view = '0;
    d.view.claim_ok = cok;
    d.view.slot_out = slot;
    return d;
  endfunction

  always @(posedge clk) begin
    view_t w;
    if (rst_n && out_valid) begin
      if (expected_views.size() == 0) begin
        $display("unexpected result beat at %0t", $time);
        errors++;
      end else begin
        w = expected_views.pop_front();
        if (out_claim_ok !== w.claim_ok) report("claim_ok", out_claim_ok, w.claim_ok);
        if (out_slot_out !== w.slot_out) report("slot_out", out_slot_out, w.slot_out);
        if (out_frame_shown !== w.frame_shown)
          report("frame_shown", out_frame_shown, w.frame_shown);
        if (out_show_w !== w.show_w) report("show_w", out_show_w, w.show_w);
        if (out_show_h !== w.show_h) report("show_h", out_show_h, w.show_h);
        if (out_release_audio !== w.release_audio)
          report("release_audio", out_release_audio, w.release_audio);
        if (out_stream_done !== w.stream_done)
          report("stream_done", out_stream_done, w.stream_done);
        if (out_position_ns !== w.position_ns)
          report("position_ns", out_position_ns, w.position_ns);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("frame_slot_presenter: mismatch");
      $finish;
    end
  end

  initial begin
    dir_row_t dir[25];
    int ph_preroll[4];
    int ph_idle[4];
    logic [31:0] ph_timeout[4];

    for (int i = 0; i < SLOTS; i++) slot_state[i] = ST_EMPTY;
    {clock_run, ended, seek_wait, paused, on_audio, have_shown} = '0;
    anchor_pts = '0; position = '0; anchor_wall = '0; paused_at = '0;
    audio_wait_t0 = '0; shown_idx = '0;
    preroll_need = 4'd4;
    audio_wait_limit = 32'd5000000;
    idle_pct = 0;
    next_pts = 63'd100000000; seek_target = '0; wall_us = 48'd1000000;

    dir[0]  = typed_row(row(OP_PRESENT, 0, 0, 0, 0, 0, 1, 0, 0), 0, 0);
    dir[1]  = typed_row(row(3'd6, 7, M63, 8191, 8191, 1, M48, 1, 1), 0, 0);
    dir[2]  = typed_row(row(3'd7, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
    dir[3]  = typed_row(row(OP_CLAIM, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0);
    dir[4]  = typed_row(row(OP_CLAIM, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1);
    dir[5]  = row(OP_CLAIM, 0, 0, 0, 0, 0, 0, 0, 0);
    dir[6]  = row(OP_CLAIM, 0, 0, 0, 0, 0, 0, 0, 0);
    dir[7]  = row(OP_FILL, 0, 0, 0, 0, 1, 0, 0, 0);
    dir[8]  = row(OP_FILL, 1, 33000000, 8191, 8191, 1, 0, 0, 0);
    dir[9]  = row(OP_FILL, 2, M63, 1920, 1080, 1, 0, 0, 0);
    dir[10] = row(OP_FILL, 5, 5, 5, 5, 1, 0, 0, 0);
    dir[11] = row(OP_PRESENT, 0, 0, 0, 0, 0, 100, 1, 0);
    dir[12] = row(OP_FILL, 3, 66000000, 640, 480, 1, 0, 0, 0);
    dir[13] = row(OP_PRESENT, 0, 0, 0, 0, 0, 200, 1, 0);
    dir[14] = row(OP_PRESENT, 0, 0, 0, 0, 0, 40300, 0, 0);
    dir[15] = row(OP_PAUSE, 0, 0, 0, 0, 0, 40400, 0, 1);
    dir[16] = row(OP_PRESENT, 0, 0, 0, 0, 0, 90000, 0, 0);
    dir[17] = row(OP_PAUSE, 0, 0, 0, 0, 0, 90500, 0, 0);
    dir[18] = row(OP_SEEK, 0, 1000, 0, 0, 0, 0, 0, 0);
    dir[19] = row(OP_PRESENT, 0, 0, 0, 0, 0, 95000, 0, 0);
    dir[20] = row(OP_LAND, 0, 1000, 0, 0, 0, 0, 0, 0);
    dir[21] = row(OP_LAND, 0, M63, 0, 0, 0, 0, 0, 0);
    dir[22] = row(OP_CLAIM, 0, 0, 0, 0, 0, 0, 0, 0);
    dir[23] = row(OP_FILL, 2, 0, 0, 0, 0, 0, 0, 0);
    dir[24] = row(OP_PRESENT, 0, 0, 0, 0, 0, M48, 0, 0);

    ph_preroll = '{1, 8, 0, 3};
    ph_timeout = '{32'd0, 32'hffffffff, 32'd60000, 32'd5000000};
    ph_idle = '{0, 71, 36, 0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir[i]) issue(dir[i].item, dir[i].typed, dir[i].view);

    for (int ph = 0; ph < 4; ph++) begin
      // Registers only change once every result of the previous phase is in.
      drain();
      cfg_write(CFG_PREROLL, 32'(ph_preroll[ph]));
      cfg_write(CFG_TIMEOUT, ph_timeout[ph]);
      idle_pct = ph_idle[ph];
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        sender_gap();
        issue(session_item(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("frame_slot_presenter: match");
    else $display("frame_slot_presenter: mismatch");
    $finish;
  end
endmodule

### filelist.f
src/fsp_pkg.sv
src/fsp_ctrl.sv
src/fsp_dp.sv
src/frame_slot_presenter.sv
verif/tb.sv
